[hw/rtl/cdeq_pkg.sv]
// shared widths, command codes and constants of the circular deque
package cdeq_pkg;

    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int CAP_W = 11;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [CAP_W-1:0] t_cap;

    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_REAR  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_REAR   = 3'd3;
    localparam t_cmd CMD_STATUS     = 3'd4;

    localparam t_cap CAP_RESET = 11'd1024;
    localparam t_val VAL_NONE  = '1;

endpackage

[hw/rtl/cdeq_cmd_if.sv]
// command channel of the circular deque
interface cdeq_cmd_if;
    logic           valid;
    logic           ready;
    cdeq_pkg::t_cmd cmd;
    cdeq_pkg::t_val value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

[hw/rtl/cdeq_rsp_if.sv]
// result channel of the circular deque
interface cdeq_rsp_if;
    logic           valid;
    logic           ready;
    logic           ok;
    cdeq_pkg::t_val front_value;
    cdeq_pkg::t_val rear_value;
    logic           is_empty;
    logic           is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

[hw/rtl/cdeq_cfg_if.sv]
// capacity write channel of the circular deque
interface cdeq_cfg_if;
    logic           valid;
    logic           ready;
    cdeq_pkg::t_cap capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink (input valid, input capacity_in_use, output ready);
endinterface

[hw/rtl/cdeq_ram.sv]
// generic single write port ram with registered read
module cdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/circular_double_ended_queue.sv]
// circular double-ended queue top level
//
// Usage:
//   i_cmd carries one command per transfer: push front, push rear, pop front,
//   pop rear or status (codes 5 to 7 also act as status). o_rsp returns one
//   result per command: ok, front and rear values after the command (all ones
//   when empty), is_empty and is_full.
//   i_cfg writes capacity_in_use (0 acts as 1, above DEPTH acts as DEPTH);
//   it is always ready; write it only while no command is in flight (the block does not enforce this).
// Timing:
//   pushes and status commands, and pops that leave the queue empty or with
//   an unchanged end, finish in S_IDLE and load the result straight into the
//   output register; a new command is taken every cycle while o_rsp is not held.
//   a pop that exposes a new front or rear first passes through S_READ,
//   waiting for the registered read of the ring memory.
//   the front and rear elements are cached in registers, so the single ring
//   memory port pair (one write, one read) serves every command.
// Reset: head, tail and count clear and the capacity returns to 1024;
//   the ring memory needs no clearing pass since every read entry was written.
// Stall: when o_rsp is held, one finished command waits inside the block
//   and the block stops taking commands until the output register frees.
module circular_double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdeq_cmd_if.sink   i_cmd,
    cdeq_cfg_if.sink   i_cfg,
    cdeq_rsp_if.source o_rsp
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CAPW = (CW > cdeq_pkg::CAP_W) ? CW : cdeq_pkg::CAP_W;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_HOLD} t_state;

    t_state         r_state, n_state;
    logic [IW-1:0]  r_head, n_head;
    logic [IW-1:0]  r_tail, n_tail;
    logic [CW-1:0]  r_count, n_count;
    cdeq_pkg::t_cap r_cap;
    cdeq_pkg::t_val r_front, n_front;
    cdeq_pkg::t_val r_rear, n_rear;
    logic           r_ok, n_ok;
    logic           r_rd_front, n_rd_front;

    logic           r_out_valid;
    logic           r_out_ok;
    cdeq_pkg::t_val r_out_front;
    cdeq_pkg::t_val r_out_rear;
    logic           r_out_empty;
    logic           r_out_full;

    logic [CAPW-1:0] cap;
    logic            accept;
    logic            slot_free;
    logic            load;
    logic            full;
    logic            empty;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    cdeq_pkg::t_val  rd_data;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx,
                                              input logic [CAPW-1:0] c);
        logic [CAPW-1:0] nxt;
        nxt = CAPW'(idx) + CAPW'(1);
        return (nxt >= c) ? '0 : IW'(nxt);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx,
                                              input logic [CAPW-1:0] c);
        return (idx == '0) ? IW'(c - CAPW'(1)) : idx - IW'(1);
    endfunction

    always_comb begin
        if (r_cap == '0) begin
            cap = CAPW'(1);
        end else if (CAPW'(r_cap) > CAPW'(DEPTH)) begin
            cap = CAPW'(DEPTH);
        end else begin
            cap = CAPW'(r_cap);
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign full        = CAPW'(r_count) >= cap;
    assign empty       = (r_count == '0);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_front    = r_front;
        n_rear     = r_rear;
        n_ok       = r_ok;
        n_rd_front = r_rd_front;
        load       = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_head;
        rd_en      = 1'b0;
        rd_addr    = r_head;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ok = 1'b1;
                    case (i_cmd.cmd)
                        cdeq_pkg::CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_ok = 1'b0;
                            end else begin
                                if (!empty) begin
                                    n_head = idx_dec(r_head, cap);
                                end
                                // written entry may also be the rear one
                                if (n_head == r_tail) begin
                                    n_rear = i_cmd.value;
                                end
                                n_front = i_cmd.value;
                                wr_en   = 1'b1;
                                wr_addr = n_head;
                                n_count = r_count + CW'(1);
                            end
                        end
                        cdeq_pkg::CMD_PUSH_REAR: begin
                            if (full) begin
                                n_ok = 1'b0;
                            end else begin
                                if (!empty) begin
                                    n_tail = idx_inc(r_tail, cap);
                                end
                                // written entry may also be the front one
                                if (n_tail == r_head) begin
                                    n_front = i_cmd.value;
                                end
                                n_rear  = i_cmd.value;
                                wr_en   = 1'b1;
                                wr_addr = n_tail;
                                n_count = r_count + CW'(1);
                            end
                        end
                        cdeq_pkg::CMD_POP_FRONT: begin
                            if (empty) begin
                                n_ok = 1'b0;
                            end else begin
                                if (r_count != CW'(1)) begin
                                    n_head     = idx_inc(r_head, cap);
                                    rd_en      = 1'b1;
                                    rd_addr    = n_head;
                                    n_rd_front = 1'b1;
                                end
                                n_count = r_count - CW'(1);
                            end
                        end
                        cdeq_pkg::CMD_POP_REAR: begin
                            if (empty) begin
                                n_ok = 1'b0;
                            end else begin
                                if (r_count != CW'(1)) begin
                                    n_tail     = idx_dec(r_tail, cap);
                                    rd_en      = 1'b1;
                                    rd_addr    = n_tail;
                                    n_rd_front = 1'b0;
                                end
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (rd_en) begin
                        n_state = S_READ;
                    end else if (slot_free) begin
                        load = 1'b1;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_READ: begin
                if (r_rd_front) begin
                    n_front = rd_data;
                end else begin
                    n_rear = rd_data;
                end
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    cdeq_ram #(
        .WIDTH (cdeq_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cap       <= cdeq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.capacity_in_use;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_front    <= n_front;
        r_rear     <= n_rear;
        r_ok       <= n_ok;
        r_rd_front <= n_rd_front;
        if (load) begin
            r_out_ok    <= n_ok;
            r_out_empty <= (n_count == '0);
            r_out_full  <= CAPW'(n_count) >= cap;
            r_out_front <= (n_count == '0) ? cdeq_pkg::VAL_NONE : n_front;
            r_out_rear  <= (n_count == '0) ? cdeq_pkg::VAL_NONE : n_rear;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.rear_value  = r_out_rear;
    assign o_rsp.is_empty    = r_out_empty;
    assign o_rsp.is_full     = r_out_full;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CAPW'(r_count) <= CAPW'(DEPTH)) && (CAPW'(r_head) < CAPW'(DEPTH))
        && (CAPW'(r_tail) < CAPW'(DEPTH)))
        else $error("deque count or index out of range");

    a_read_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> $past(accept))
        else $error("ring read without an accepted pop");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.is_empty) |-> (o_rsp.front_value == cdeq_pkg::VAL_NONE)
        && (o_rsp.rear_value == cdeq_pkg::VAL_NONE) && !o_rsp.is_full)
        else $error("empty result carries element values or full flag");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out_front)
        && $stable(r_out_rear) && $stable(r_out_ok)))
        else $error("pending result overwritten");
`endif

endmodule
